@@ hw/rtl/bsa_pkg.sv @@
// Shared types, codes and default sizes of the deadlock-avoidance allocator.
// No dependencies; every other file of the block but bsa_ram imports it.
package bsa_pkg;

  // Default sizes for the top-level parameters
  localparam int PROCESSES_DEF  = 8;
  localparam int RESOURCES_DEF  = 4;
  localparam int COUNT_BITS_DEF = 8;

  // Fixed field widths of the stream words
  localparam int MODE_W     = 3;
  localparam int PROC_W     = 3;
  localparam int RES_W      = 2;
  localparam int VALUE_W    = 8;
  localparam int STATUS_W   = 3;
  localparam int ENTRY_W    = 3;
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int PCFG_W     = 4;
  localparam int RCFG_W     = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RES   = 1'b1;
  localparam logic [PCFG_W-1:0]    PCFG_RESET = 4'd8;
  localparam logic [RCFG_W-1:0]    RCFG_RESET = 3'd4;

  // Input modes
  localparam logic [MODE_W-1:0] MODE_LOAD_AVAIL = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_ALLOC = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD_NEED  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CHECK      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REQUEST    = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_LOADED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SAFE       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNSAFE     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_GRANTED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVER_NEED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVER_AVAIL = 3'd5;
  localparam logic [STATUS_W-1:0] ST_REFUSED    = 3'd6;

  // One result word on its way to the output register
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ENTRY_W-1:0]  entry;
    logic                last;
  } result_t;

endpackage

@@ hw/rtl/bsa_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/bsa_out_reg.sv @@
// Output register of the result stream; frees the sequencer from the sink.
// Depends on bsa_pkg for the result word type.
module bsa_out_reg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          res_valid_i,
  input  bsa_pkg::result_t              res_i,
  output logic                          res_ready_o,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [bsa_pkg::OUT_TDATA_W-1:0] m_data_o,
  output logic [bsa_pkg::STATUS_W-1:0]  m_user_o,
  output logic                          m_last_o
);
  import bsa_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // Slot is free when empty or being drained this cycle
  assign res_ready_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_ready_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = OUT_TDATA_W'(res_q.entry);
  assign m_user_o  = res_q.status;
  assign m_last_o  = res_q.last;

endmodule

@@ hw/rtl/bsa_ctrl.sv @@
// Sequencer of the allocator: loads, safety passes, request judgment, result posting.
// Depends on bsa_pkg; drives the table RAMs and the order RAM built in the top level.
module bsa_ctrl #(
  parameter int PROCESSES  = bsa_pkg::PROCESSES_DEF,
  parameter int RESOURCES  = bsa_pkg::RESOURCES_DEF,
  parameter int COUNT_BITS = bsa_pkg::COUNT_BITS_DEF,
  localparam int PB = $clog2(PROCESSES),
  localparam int RB = (RESOURCES > 1) ? $clog2(RESOURCES) : 1,
  localparam int AW = PB + RB
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bsa_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // input stream
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bsa_pkg::IN_TDATA_W-1:0]  in_data_i,
  input  logic [bsa_pkg::MODE_W-1:0]      in_user_i,
  input  logic                            in_last_i,
  // allocation and need tables
  output logic                            need_we_o,
  output logic                            alloc_we_o,
  output logic [AW-1:0]                   tab_waddr_o,
  output logic [COUNT_BITS-1:0]           need_wdata_o,
  output logic [COUNT_BITS-1:0]           alloc_wdata_o,
  output logic [AW-1:0]                   tab_raddr_o,
  input  logic [COUNT_BITS-1:0]           need_rdata_i,
  input  logic [COUNT_BITS-1:0]           alloc_rdata_i,
  // safe order memory
  output logic                            ord_we_o,
  output logic [PB-1:0]                   ord_waddr_o,
  output logic [PB-1:0]                   ord_wdata_o,
  output logic [PB-1:0]                   ord_raddr_o,
  input  logic [PB-1:0]                   ord_rdata_i,
  // result words
  output logic                            res_valid_o,
  output bsa_pkg::result_t                res_o,
  input  logic                            res_ready_i
);
  import bsa_pkg::*;

  localparam int CB    = COUNT_BITS;
  localparam int WB    = COUNT_BITS + 4;
  localparam int WX    = WB + 1;
  localparam int CX    = CB + 1;
  localparam int VW    = (CB > VALUE_W) ? CB : VALUE_W;
  localparam int NPW   = $clog2(PROCESSES + 1);
  localparam int RW    = $clog2(RESOURCES + 1);
  localparam int DEPTH = PROCESSES << RB;
  localparam int COUNT_MAX = (1 << CB) - 1;

  // Sequencer states
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_POST  = 4'd2;
  localparam logic [3:0] S_CINIT = 4'd3;
  localparam logic [3:0] S_CPROC = 4'd4;
  localparam logic [3:0] S_CRD   = 4'd5;
  localparam logic [3:0] S_CEV   = 4'd6;
  localparam logic [3:0] S_EMRD  = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;
  localparam logic [3:0] S_JRD   = 4'd9;
  localparam logic [3:0] S_JEV   = 4'd10;
  localparam logic [3:0] S_JAPP  = 4'd11;
  localparam logic [3:0] S_JRST  = 4'd12;

  logic [3:0]          state_q, state_d;
  logic [PCFG_W-1:0]   proc_cfg_q;
  logic [RCFG_W-1:0]   res_cfg_q;
  logic [CB-1:0]       avail_q [RESOURCES];
  logic [CB-1:0]       avail_d [RESOURCES];
  logic [CB-1:0]       req_q [RESOURCES];
  logic [CB-1:0]       req_d [RESOURCES];
  logic [WB-1:0]       work_q [RESOURCES];
  logic [WB-1:0]       work_d [RESOURCES];
  logic [WB-1:0]       cand_q [RESOURCES];
  logic [WB-1:0]       cand_d [RESOURCES];
  logic [CB-1:0]       sn_q [RESOURCES];
  logic [CB-1:0]       sn_d [RESOURCES];
  logic [CB-1:0]       sl_q [RESOURCES];
  logic [CB-1:0]       sl_d [RESOURCES];
  logic [CB-1:0]       sa_q [RESOURCES];
  logic [CB-1:0]       sa_d [RESOURCES];
  logic [PROCESSES-1:0] fin_q, fin_d;
  logic [PB-1:0]       i_q, i_d;
  logic [RB-1:0]       j_q, j_d;
  logic [PB-1:0]       k_q, k_d;
  logic [NPW-1:0]      n_q, n_d;
  logic [PB-1:0]       jp_q, jp_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic                progress_q, progress_d;
  logic                fits_q, fits_d;
  logic                judging_q, judging_d;
  logic [STATUS_W-1:0] post_q, post_d;

  // Input word fields
  logic [PROC_W-1:0]  in_p;
  logic [RES_W-1:0]   in_r;
  logic [VALUE_W-1:0] in_v;
  logic               p_ok, r_ok, acc;
  logic [VW-1:0]      v_ext;
  logic [CB-1:0]      v_sat;

  assign in_p  = in_data_i[PROC_W-1:0];
  assign in_r  = in_data_i[PROC_W+RES_W-1:PROC_W];
  assign in_v  = in_data_i[PROC_W+RES_W+VALUE_W-1:PROC_W+RES_W];
  assign p_ok  = int'(in_p) < PROCESSES;
  assign r_ok  = int'(in_r) < RESOURCES;
  assign v_ext = VW'(in_v);
  assign v_sat = (v_ext > VW'(COUNT_MAX)) ? {CB{1'b1}} : CB'(v_ext);

  assign in_ready_o = (state_q == S_IDLE);
  assign acc        = in_valid_i && in_ready_o;

  // Clamped process and resource counts
  logic [NPW-1:0] np;
  logic [RW-1:0]  nr;

  always_comb begin
    if (proc_cfg_q == '0) begin
      np = NPW'(1);
    end else if (int'(proc_cfg_q) > PROCESSES) begin
      np = NPW'(PROCESSES);
    end else begin
      np = NPW'(proc_cfg_q);
    end
    if (res_cfg_q == '0) begin
      nr = RW'(1);
    end else if (int'(res_cfg_q) > RESOURCES) begin
      nr = RW'(RESOURCES);
    end else begin
      nr = RW'(res_cfg_q);
    end
  end

  // Per-element arithmetic on the table read data
  logic [WX-1:0] work_sum;
  logic [WB-1:0] cand_now;
  logic          fits_now;
  logic [CX-1:0] alloc_sum;
  logic [CB-1:0] alloc_new;
  logic          j_last, i_last, k_last;

  assign work_sum  = {1'b0, work_q[j_q]} + WX'(alloc_rdata_i);
  assign cand_now  = work_sum[WB] ? {WB{1'b1}} : work_sum[WB-1:0];
  assign fits_now  = fits_q && (WB'(need_rdata_i) <= work_q[j_q]);
  assign alloc_sum = {1'b0, sl_q[j_q]} + CX'(req_q[j_q]);
  assign alloc_new = alloc_sum[CB] ? {CB{1'b1}} : alloc_sum[CB-1:0];
  assign j_last    = (RW'(j_q) + RW'(1)) == nr;
  assign i_last    = (NPW'(i_q) + NPW'(1)) == np;
  assign k_last    = (NPW'(k_q) + NPW'(1)) == n_q;

  // Main sequencer
  logic advance;

  always_comb begin
    state_d    = state_q;
    avail_d    = avail_q;
    req_d      = req_q;
    work_d     = work_q;
    cand_d     = cand_q;
    sn_d       = sn_q;
    sl_d       = sl_q;
    sa_d       = sa_q;
    fin_d      = fin_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    n_d        = n_q;
    jp_d       = jp_q;
    clr_d      = clr_q;
    progress_d = progress_q;
    fits_d     = fits_q;
    judging_d  = judging_q;
    post_d     = post_q;
    advance    = 1'b0;

    need_we_o     = 1'b0;
    alloc_we_o    = 1'b0;
    tab_waddr_o   = {PB'(in_p), RB'(in_r)};
    need_wdata_o  = v_sat;
    alloc_wdata_o = v_sat;
    tab_raddr_o   = {i_q, j_q};
    ord_we_o      = 1'b0;
    ord_waddr_o   = PB'(n_q);
    ord_wdata_o   = i_q;
    ord_raddr_o   = k_q;
    res_valid_o   = 1'b0;
    res_o         = '{status: post_q, entry: '0, last: 1'b1};

    case (state_q)
      // zero both tables, one entry a cycle
      S_CLEAR: begin
        need_we_o     = 1'b1;
        alloc_we_o    = 1'b1;
        tab_waddr_o   = clr_q;
        need_wdata_o  = '0;
        alloc_wdata_o = '0;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end

      S_IDLE: begin
        if (acc) begin
          case (in_user_i)
            MODE_LOAD_AVAIL: begin
              if (r_ok) begin
                avail_d[RB'(in_r)] = v_sat;
              end
              post_d  = ST_LOADED;
              state_d = S_POST;
            end
            MODE_LOAD_ALLOC: begin
              alloc_we_o = p_ok && r_ok;
              post_d     = ST_LOADED;
              state_d    = S_POST;
            end
            MODE_LOAD_NEED: begin
              need_we_o = p_ok && r_ok;
              post_d    = ST_LOADED;
              state_d   = S_POST;
            end
            MODE_CHECK: begin
              judging_d = 1'b0;
              state_d   = S_CINIT;
            end
            MODE_REQUEST: begin
              if (r_ok) begin
                req_d[RB'(in_r)] = v_sat;
              end
              if (in_last_i) begin
                if (!p_ok) begin
                  for (int r = 0; r < RESOURCES; r++) begin
                    req_d[r] = '0;
                  end
                  post_d  = ST_OVER_NEED;
                  state_d = S_POST;
                end else begin
                  jp_d      = PB'(in_p);
                  j_d       = '0;
                  judging_d = 1'b1;
                  state_d   = S_JRD;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_POST: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      // start of a safety test
      S_CINIT: begin
        for (int r = 0; r < RESOURCES; r++) begin
          work_d[r] = WB'(avail_q[r]);
        end
        fin_d      = '0;
        i_d        = '0;
        n_d        = '0;
        progress_d = 1'b0;
        state_d    = S_CPROC;
      end

      S_CPROC: begin
        if (fin_q[i_q]) begin
          advance = 1'b1;
        end else begin
          j_d     = '0;
          fits_d  = 1'b1;
          state_d = S_CRD;
        end
      end

      S_CRD: begin
        state_d = S_CEV;
      end

      // need and allocation of element (i, j) are on the read ports
      S_CEV: begin
        cand_d[j_q] = cand_now;
        if (j_last) begin
          if (fits_now) begin
            for (int r = 0; r < RESOURCES; r++) begin
              if (r < int'(nr)) begin
                work_d[r] = (r == int'(j_q)) ? cand_now : cand_q[r];
              end
            end
            fin_d[i_q] = 1'b1;
            ord_we_o   = 1'b1;
            n_d        = n_q + NPW'(1);
            progress_d = 1'b1;
          end
          advance = 1'b1;
        end else begin
          j_d     = j_q + RB'(1);
          fits_d  = fits_now;
          state_d = S_CRD;
        end
      end

      S_EMRD: begin
        state_d = S_EMIT;
      end

      S_EMIT: begin
        res_valid_o = 1'b1;
        res_o       = '{status: judging_q ? ST_GRANTED : ST_SAFE,
                        entry:  ENTRY_W'(ord_rdata_i),
                        last:   k_last};
        if (res_ready_i) begin
          if (k_last) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + PB'(1);
            state_d = S_EMRD;
          end
        end
      end

      S_JRD: begin
        tab_raddr_o = {jp_q, j_q};
        state_d     = S_JEV;
      end

      // request element j against need, then available
      S_JEV: begin
        tab_raddr_o = {jp_q, j_q};
        sn_d[j_q]   = need_rdata_i;
        sl_d[j_q]   = alloc_rdata_i;
        if (req_q[j_q] > need_rdata_i) begin
          for (int r = 0; r < RESOURCES; r++) begin
            req_d[r] = '0;
          end
          post_d  = ST_OVER_NEED;
          state_d = S_POST;
        end else if (req_q[j_q] > avail_q[j_q]) begin
          for (int r = 0; r < RESOURCES; r++) begin
            req_d[r] = '0;
          end
          post_d  = ST_OVER_AVAIL;
          state_d = S_POST;
        end else if (j_last) begin
          j_d     = '0;
          state_d = S_JAPP;
        end else begin
          j_d     = j_q + RB'(1);
          state_d = S_JRD;
        end
      end

      // tentative grant
      S_JAPP: begin
        need_we_o     = 1'b1;
        alloc_we_o    = 1'b1;
        tab_waddr_o   = {jp_q, j_q};
        need_wdata_o  = sn_q[j_q] - req_q[j_q];
        alloc_wdata_o = alloc_new;
        sa_d[j_q]     = avail_q[j_q];
        avail_d[j_q]  = avail_q[j_q] - req_q[j_q];
        if (j_last) begin
          state_d = S_CINIT;
        end else begin
          j_d = j_q + RB'(1);
        end
      end

      // roll back a grant that left the state unsafe
      S_JRST: begin
        need_we_o     = 1'b1;
        alloc_we_o    = 1'b1;
        tab_waddr_o   = {jp_q, j_q};
        need_wdata_o  = sn_q[j_q];
        alloc_wdata_o = sl_q[j_q];
        avail_d[j_q]  = sa_q[j_q];
        if (j_last) begin
          post_d  = ST_REFUSED;
          state_d = S_POST;
        end else begin
          j_d = j_q + RB'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // next process; a pass that finished nothing ends the test
    if (advance) begin
      if (i_last) begin
        if (progress_d) begin
          i_d        = '0;
          progress_d = 1'b0;
          state_d    = S_CPROC;
        end else begin
          if (judging_q) begin
            for (int r = 0; r < RESOURCES; r++) begin
              req_d[r] = '0;
            end
          end
          if (n_d == np) begin
            k_d     = '0;
            state_d = S_EMRD;
          end else if (judging_q) begin
            j_d     = '0;
            state_d = S_JRST;
          end else begin
            post_d  = ST_UNSAFE;
            state_d = S_POST;
          end
        end
      end else begin
        i_d     = i_q + PB'(1);
        state_d = S_CPROC;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      proc_cfg_q <= PCFG_RESET;
      res_cfg_q  <= RCFG_RESET;
      for (int r = 0; r < RESOURCES; r++) begin
        avail_q[r] <= '0;
        req_q[r]   <= '0;
      end
      fin_q      <= '0;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      n_q        <= '0;
      jp_q       <= '0;
      clr_q      <= '0;
      progress_q <= 1'b0;
      fits_q     <= 1'b0;
      judging_q  <= 1'b0;
      post_q     <= ST_LOADED;
    end else begin
      state_q    <= state_d;
      avail_q    <= avail_d;
      req_q      <= req_d;
      fin_q      <= fin_d;
      i_q        <= i_d;
      j_q        <= j_d;
      k_q        <= k_d;
      n_q        <= n_d;
      jp_q       <= jp_d;
      clr_q      <= clr_d;
      progress_q <= progress_d;
      fits_q     <= fits_d;
      judging_q  <= judging_d;
      post_q     <= post_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PROCS: proc_cfg_q <= cfg_data_i;
          CFG_RES:   res_cfg_q  <= cfg_data_i[RCFG_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Working vectors and saved rows
  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    cand_q <= cand_d;
    sn_q   <= sn_d;
    sl_q   <= sl_d;
    sa_q   <= sa_d;
  end

endmodule

@@ hw/rtl/bankers_safety_allocator_unit.sv @@
// Deadlock-avoidance allocator top level: tables in RAM, sequencer, output register.
// Depends on bsa_pkg, bsa_ram, bsa_ctrl and bsa_out_reg.
//
// A load word is accepted, then its loaded status is posted. A request element
// that is not the last one is only stored. A safety check starts by loading the
// work vector from the available counts, then per pass visits each process and,
// for each resource in use of every process not yet finished, reads need and
// allocation from the table RAMs one element per read and evaluates the registered
// read data; at most one pass more than processes in use is made, the last one
// finishing nothing. A safe order is then sent word by word out of the order RAM.
// A judged request adds a scan that reads and checks each resource, then applies
// the grant resource by resource, and rolls it back the same way when refused.
// After reset the block clears all PROCESSES times 2**RB entries (32 at default
// sizes) of both tables with s_axis_tready low.
module bankers_safety_allocator_unit #(
  parameter int PROCESSES  = bsa_pkg::PROCESSES_DEF,
  parameter int RESOURCES  = bsa_pkg::RESOURCES_DEF,
  parameter int COUNT_BITS = bsa_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bsa_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bsa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // process, resource, value, zero pad
  input  logic [bsa_pkg::MODE_W-1:0]      s_axis_tuser,  // mode
  input  logic                            s_axis_tlast,  // final_element
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bsa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // order_entry, zero pad
  output logic [bsa_pkg::STATUS_W-1:0]    m_axis_tuser,  // status
  output logic                            m_axis_tlast   // last
);
  import bsa_pkg::*;

  localparam int PB    = $clog2(PROCESSES);
  localparam int RB    = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
  localparam int AW    = PB + RB;
  localparam int DEPTH = PROCESSES << RB;

  logic                  need_we, alloc_we, ord_we;
  logic [AW-1:0]         tab_waddr, tab_raddr;
  logic [COUNT_BITS-1:0] need_wdata, alloc_wdata, need_rdata, alloc_rdata;
  logic [PB-1:0]         ord_waddr, ord_wdata, ord_raddr, ord_rdata;
  logic                  res_valid, res_ready;
  result_t               res;

  bsa_ctrl #(
    .PROCESSES  (PROCESSES),
    .RESOURCES  (RESOURCES),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_data_i     (s_axis_tdata),
    .in_user_i     (s_axis_tuser),
    .in_last_i     (s_axis_tlast),
    .need_we_o     (need_we),
    .alloc_we_o    (alloc_we),
    .tab_waddr_o   (tab_waddr),
    .need_wdata_o  (need_wdata),
    .alloc_wdata_o (alloc_wdata),
    .tab_raddr_o   (tab_raddr),
    .need_rdata_i  (need_rdata),
    .alloc_rdata_i (alloc_rdata),
    .ord_we_o      (ord_we),
    .ord_waddr_o   (ord_waddr),
    .ord_wdata_o   (ord_wdata),
    .ord_raddr_o   (ord_raddr),
    .ord_rdata_i   (ord_rdata),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_ready_i   (res_ready)
  );

  // Need table, one entry per (process, resource)
  bsa_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_need_ram (
    .clk_i   (clk_i),
    .we_i    (need_we),
    .waddr_i (tab_waddr),
    .wdata_i (need_wdata),
    .raddr_i (tab_raddr),
    .rdata_o (need_rdata)
  );

  // Allocation table, same addressing
  bsa_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_alloc_ram (
    .clk_i   (clk_i),
    .we_i    (alloc_we),
    .waddr_i (tab_waddr),
    .wdata_i (alloc_wdata),
    .raddr_i (tab_raddr),
    .rdata_o (alloc_rdata)
  );

  // Safe order of the last test
  bsa_ram #(.WIDTH(PB), .DEPTH(PROCESSES)) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  bsa_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_user_o    (m_axis_tuser),
    .m_last_o    (m_axis_tlast)
  );

endmodule

@@ hw/rtl/bsa_checker.sv @@
// Port-level assertions for the allocator, bound to the top level.
// Depends on bsa_pkg and bankers_safety_allocator_unit.
module bsa_port_props (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [bsa_pkg::MODE_W-1:0]      s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bsa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [bsa_pkg::STATUS_W-1:0]    m_axis_tuser,
  input logic                            m_axis_tlast
);
  import bsa_pkg::*;

  // Single-word results carry no order entry and close their run
  a_single_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_SAFE && m_axis_tuser != ST_GRANTED
    |-> m_axis_tlast && m_axis_tdata == '0)
    else $error("single-word result with entry or without last");

  // No status code beyond the refused one
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= ST_REFUSED)
    else $error("undefined status code");

  // Pad bits above the order entry stay zero
  a_entry_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:ENTRY_W] == '0)
    else $error("order entry pad bits set");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready
    |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
        && $stable(m_axis_tlast))
    else $error("stalled result word changed");

  // Loads and checks each owe a result, so intake pauses after them
  a_intake_pause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready
    && (s_axis_tuser == MODE_LOAD_AVAIL || s_axis_tuser == MODE_LOAD_ALLOC
        || s_axis_tuser == MODE_LOAD_NEED || s_axis_tuser == MODE_CHECK)
    |=> !s_axis_tready)
    else $error("word taken while a result is still owed");

endmodule

bind bankers_safety_allocator_unit bsa_port_props u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
